FILE: hdl/qrv_pkg.sv
// ---------------------------------------------------------------------------
// qrv_pkg
// Shared types and constants for the quaternion vector rotation pipeline.
// ---------------------------------------------------------------------------
package qrv_pkg;

    localparam int VEC_W     = 32;                 // Q16.16 vector components
    localparam int QUAT_W    = 16;                 // Q1.14 quaternion components
    localparam int QPROD_W   = 2 * QUAT_W;         // quaternion pair products
    localparam int COEF_W    = QPROD_W + 2;        // rotation matrix entries
    localparam int PROD_W    = COEF_W + VEC_W;     // matrix entry times component
    localparam int ACC_W     = PROD_W + 2;         // sum of three products
    localparam int RND_SHIFT = 28;                 // Q2.28 * Q16.16 -> Q16.16
    localparam int SHR_W     = ACC_W - RND_SHIFT;  // width after the shift
    localparam int CFG_IDX_W = 8;

    typedef logic signed [VEC_W-1:0]   t_vec;
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [QPROD_W-1:0] t_qprod;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [SHR_W-1:0]   t_shr;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X = CFG_IDX_W'(0),
        REG_QUAT_Y = CFG_IDX_W'(1),
        REG_QUAT_Z = CFG_IDX_W'(2),
        REG_QUAT_W = CFG_IDX_W'(3)
    } t_reg_idx;

    // one row of the rotation matrix
    typedef struct packed {
        t_coef c0;
        t_coef c1;
        t_coef c2;
    } t_coef_row;

    // stage load enables for the dot product rows
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_out;
    } t_pipe_en;

    localparam t_acc RND_HALF = t_acc'(1) <<< (RND_SHIFT - 1);
    localparam t_vec VEC_MAX  = {1'b0, {(VEC_W-1){1'b1}}};
    localparam t_vec VEC_MIN  = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

FILE: hdl/qrv_coef.sv
// ---------------------------------------------------------------------------
// qrv_coef
// Quaternion registers and the rotation matrix derived from them.
// ---------------------------------------------------------------------------
module qrv_coef (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [qrv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qrv_pkg::QUAT_W-1:0]    i_cfg_data,
    output qrv_pkg::t_coef_row           o_row_x,
    output qrv_pkg::t_coef_row           o_row_y,
    output qrv_pkg::t_coef_row           o_row_z
);

    qrv_pkg::t_quat r_qx, r_qy, r_qz, r_qw;
    qrv_pkg::t_coef_row r_row_x, r_row_y, r_row_z;
    qrv_pkg::t_coef_row n_row_x, n_row_y, n_row_z;

    qrv_pkg::t_coef ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= qrv_pkg::t_quat'(16384);
        end else if (i_cfg_we) begin
            case (qrv_pkg::t_reg_idx'(i_cfg_idx))
                qrv_pkg::REG_QUAT_X: r_qx <= i_cfg_data;
                qrv_pkg::REG_QUAT_Y: r_qy <= i_cfg_data;
                qrv_pkg::REG_QUAT_Z: r_qz <= i_cfg_data;
                qrv_pkg::REG_QUAT_W: r_qw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ww = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qw * r_qw));
        xx = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qx * r_qx));
        yy = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qy * r_qy));
        zz = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qz * r_qz));
        xy = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qx * r_qy));
        xz = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qx * r_qz));
        yz = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qy * r_qz));
        wx = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qw * r_qx));
        wy = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qw * r_qy));
        wz = qrv_pkg::t_coef'(qrv_pkg::t_qprod'(r_qw * r_qz));

        n_row_x.c0 = ww + xx - yy - zz;
        n_row_x.c1 = (xy - wz) <<< 1;
        n_row_x.c2 = (xz + wy) <<< 1;
        n_row_y.c0 = (xy + wz) <<< 1;
        n_row_y.c1 = ww - xx + yy - zz;
        n_row_y.c2 = (yz - wx) <<< 1;
        n_row_z.c0 = (xz - wy) <<< 1;
        n_row_z.c1 = (yz + wx) <<< 1;
        n_row_z.c2 = ww - xx - yy + zz;
    end

    always_ff @(posedge i_clk) begin
        r_row_x <= n_row_x;
        r_row_y <= n_row_y;
        r_row_z <= n_row_z;
    end

    assign o_row_x = r_row_x;
    assign o_row_y = r_row_y;
    assign o_row_z = r_row_z;

endmodule

FILE: hdl/qrv_dot.sv
// ---------------------------------------------------------------------------
// qrv_dot
// One output component: three products, sum with rounding, shift and clamp.
// ---------------------------------------------------------------------------
module qrv_dot (
    input  logic               i_clk,
    input  qrv_pkg::t_pipe_en  i_en,
    input  qrv_pkg::t_coef_row i_row,
    input  qrv_pkg::t_vec      i_vx,
    input  qrv_pkg::t_vec      i_vy,
    input  qrv_pkg::t_vec      i_vz,
    output qrv_pkg::t_vec      o_rot
);

    qrv_pkg::t_prod r_p0, r_p1, r_p2;
    qrv_pkg::t_acc  r_acc, n_acc;
    qrv_pkg::t_vec  r_rot, n_rot;
    qrv_pkg::t_shr  shr;

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (i_en.en_mul) begin
            r_p0 <= qrv_pkg::t_prod'(i_row.c0) * qrv_pkg::t_prod'(i_vx);
            r_p1 <= qrv_pkg::t_prod'(i_row.c1) * qrv_pkg::t_prod'(i_vy);
            r_p2 <= qrv_pkg::t_prod'(i_row.c2) * qrv_pkg::t_prod'(i_vz);
        end
    end

    // stage 3: sum plus half LSB
    always_comb begin
        n_acc = qrv_pkg::t_acc'(r_p0) + qrv_pkg::t_acc'(r_p1)
              + qrv_pkg::t_acc'(r_p2) + qrv_pkg::RND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_sum) begin
            r_acc <= n_acc;
        end
    end

    // stage 4: shift and saturate
    always_comb begin
        shr = r_acc[qrv_pkg::ACC_W-1:qrv_pkg::RND_SHIFT];
        if (&shr[qrv_pkg::SHR_W-1:qrv_pkg::VEC_W-1] ||
            ~|shr[qrv_pkg::SHR_W-1:qrv_pkg::VEC_W-1]) begin
            n_rot = shr[qrv_pkg::VEC_W-1:0];
        end else if (shr[qrv_pkg::SHR_W-1]) begin
            n_rot = qrv_pkg::VEC_MIN;
        end else begin
            n_rot = qrv_pkg::VEC_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_out) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

FILE: hdl/quaternion_rotate_vector.sv
// ---------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates each input vector by the configured quaternion, q * v * conj(q).
// ---------------------------------------------------------------------------
// Input channel i_vec_valid / o_vec_ready carries one Q16.16 vector per item;
// output channel o_rot_valid / i_rot_ready returns the rotated vector,
// rounded to nearest and saturated to 32 bits.
// The quaternion (Q1.14) is written through i_cfg_we / i_cfg_idx /
// i_cfg_data (index 0..3 = x, y, z, w); the user must write it only while
// the pipeline is empty; the block does not enforce it. Writes to other
// indexes are dropped. The matrix is rebuilt in the cycle after a write.
// Pipeline: input register, multiply, sum with rounding, shift/saturate. A
// result is valid once its item has passed all of these stages; one item
// can be taken every cycle unless the output stalls. The multiply stage
// (nine 34x32 products) sets the clock. Each stage has its own valid bit;
// when the receiver holds i_rot_ready low, the pipeline fills its empty
// stages and then deasserts o_vec_ready. Nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity quaternion; o_vec_ready
// is low during reset.
// ---------------------------------------------------------------------------
module quaternion_rotate_vector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qrv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qrv_pkg::QUAT_W-1:0]    i_cfg_data,
    input  logic                          i_vec_valid,
    output logic                          o_vec_ready,
    input  logic [qrv_pkg::VEC_W-1:0]     i_vec_x,
    input  logic [qrv_pkg::VEC_W-1:0]     i_vec_y,
    input  logic [qrv_pkg::VEC_W-1:0]     i_vec_z,
    output logic                          o_rot_valid,
    input  logic                          i_rot_ready,
    output logic [qrv_pkg::VEC_W-1:0]     o_rot_x,
    output logic [qrv_pkg::VEC_W-1:0]     o_rot_y,
    output logic [qrv_pkg::VEC_W-1:0]     o_rot_z
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept;
    qrv_pkg::t_pipe_en pen;
    qrv_pkg::t_vec r_vx, r_vy, r_vz;
    qrv_pkg::t_coef_row row_x, row_y, row_z;
    qrv_pkg::t_vec rot_x, rot_y, rot_z;

    assign rdy4 = !r_v4 || i_rot_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_vec_ready = rdy1 && i_rst_n;
    assign accept      = i_vec_valid && o_vec_ready;

    assign pen.en_mul = r_v1 && rdy2;
    assign pen.en_sum = r_v2 && rdy3;
    assign pen.en_out = r_v3 && rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vx <= i_vec_x;
            r_vy <= i_vec_y;
            r_vz <= i_vec_z;
        end
    end

    qrv_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_row_x    (row_x),
        .o_row_y    (row_y),
        .o_row_z    (row_z)
    );

    qrv_dot u_dot_x (
        .i_clk (i_clk),
        .i_en  (pen),
        .i_row (row_x),
        .i_vx  (r_vx),
        .i_vy  (r_vy),
        .i_vz  (r_vz),
        .o_rot (rot_x)
    );

    qrv_dot u_dot_y (
        .i_clk (i_clk),
        .i_en  (pen),
        .i_row (row_y),
        .i_vx  (r_vx),
        .i_vy  (r_vy),
        .i_vz  (r_vz),
        .o_rot (rot_y)
    );

    qrv_dot u_dot_z (
        .i_clk (i_clk),
        .i_en  (pen),
        .i_row (row_z),
        .i_vx  (r_vx),
        .i_vy  (r_vy),
        .i_vz  (r_vz),
        .o_rot (rot_z)
    );

    assign o_rot_valid = r_v4;
    assign o_rot_x     = rot_x;
    assign o_rot_y     = rot_y;
    assign o_rot_z     = rot_z;

endmodule

FILE: hdl/qrv_checker.sv
// ---------------------------------------------------------------------------
// qrv_checker
// Port-level checks for quaternion_rotate_vector, bound to the top level.
// ---------------------------------------------------------------------------
module qrv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_vec_ready,
    input logic                          o_rot_valid,
    input logic                          i_rot_ready,
    input logic [qrv_pkg::VEC_W-1:0]     o_rot_x,
    input logic [qrv_pkg::VEC_W-1:0]     o_rot_y,
    input logic [qrv_pkg::VEC_W-1:0]     o_rot_z
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rot_valid && !i_rot_ready |=>
            o_rot_valid && $stable(o_rot_x) && $stable(o_rot_y) && $stable(o_rot_z))
        else $error("stalled result changed");

    // back-pressure only when the output is stalled with a full pipeline
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_vec_ready |-> o_rot_valid && !i_rot_ready)
        else $error("input stalled without output back-pressure");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rot_valid)
        else $error("result valid after reset");

    // no item taken during reset
    a_rst_noacc: assert property (@(posedge i_clk)
        !i_rst_n |-> !o_vec_ready)
        else $error("input ready during reset");

endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (.*);

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks quaternion_rotate_vector: a directed table (identity, extremes,
// rounding ties, saturation, half turns, ignored register indexes) and then
// random phases, each under a fresh quaternion. Accepted items are predicted
// by table values or a full-precision q * v * conj(q) computed here, and the
// results are compared in order with the outputs, under random idling on both
// channels and one long receiver stall.
// ---------------------------------------------------------------------------
module testbench;

    import qrv_pkg::*;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_vec z;
    } t_vec3;

    typedef enum logic {
        ROW_CFG,
        ROW_VEC
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        t_quat                  data;
        t_vec3                  vec;
        logic                   typed;
        t_vec3                  want;
    } t_row;

    localparam t_quat                Q_ONE        = 16'sd16384;
    localparam t_quat                Q_COS45      = 16'sd11585;
    localparam t_quat                Q_MOST_POS   = 16'sh7FFF;
    localparam t_quat                Q_MOST_NEG   = 16'sh8000;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = {CFG_IDX_W{1'b1}};
    localparam t_vec                 V_HALF_LSB   = 32'sd134217728;   // 2^27
    localparam int                   N_PHASES     = 12;
    localparam int                   PHASE_ITEMS  = 120;
    localparam int                   HOLD_AT      = 700;
    localparam int                   HOLD_CYCLES  = 150;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [QUAT_W-1:0]    i_cfg_data;
    logic                 i_vec_valid;
    logic                 o_vec_ready;
    logic [VEC_W-1:0]     i_vec_x;
    logic [VEC_W-1:0]     i_vec_y;
    logic [VEC_W-1:0]     i_vec_z;
    logic                 o_rot_valid;
    logic                 i_rot_ready;
    logic [VEC_W-1:0]     o_rot_x;
    logic [VEC_W-1:0]     o_rot_y;
    logic [VEC_W-1:0]     o_rot_z;

    // quaternion as the block should hold it
    t_quat quat_x;
    t_quat quat_y;
    t_quat quat_z;
    t_quat quat_w;

    t_vec3 pending_rot[$];
    t_row  dir_rows[$];
    t_vec3 table_rot;
    logic  use_table_rot;
    bit    burst_mode;
    int    mismatches;
    int    rot_seen;

    quaternion_rotate_vector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_vec_valid (i_vec_valid),
        .o_vec_ready (o_vec_ready),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_rot_valid (o_rot_valid),
        .i_rot_ready (i_rot_ready),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("testbench NOT OK");
        $finish;
    end

    // exact three-term dot product, rounded half up at bit 28, then clamped
    function automatic t_vec round_sat_dot(longint c0, longint c1, longint c2,
                                           t_vec a, t_vec b, t_vec d);
        logic signed [127:0] k0, k1, k2, v0, v1, v2, acc;
        k0 = c0;
        k1 = c1;
        k2 = c2;
        v0 = a;
        v1 = b;
        v2 = d;
        acc = k0 * v0 + k1 * v1 + k2 * v2 + (128'sd1 <<< (RND_SHIFT - 1));
        acc = acc >>> RND_SHIFT;
        if (acc > VEC_MAX) return VEC_MAX;
        if (acc < VEC_MIN) return VEC_MIN;
        return acc[VEC_W-1:0];
    endfunction

    function automatic t_vec3 rotate(t_vec vx, t_vec vy, t_vec vz);
        longint x, y, z, w;
        t_vec3  r;
        x = quat_x;
        y = quat_y;
        z = quat_z;
        w = quat_w;
        r.x = round_sat_dot(w*w + x*x - y*y - z*z, 2*(x*y - w*z), 2*(x*z + w*y),
                            vx, vy, vz);
        r.y = round_sat_dot(2*(x*y + w*z), w*w - x*x + y*y - z*z, 2*(y*z - w*x),
                            vx, vy, vz);
        r.z = round_sat_dot(2*(x*z - w*y), 2*(y*z + w*x), w*w - x*x - y*y + z*z,
                            vx, vy, vz);
        return r;
    endfunction

    function automatic t_row crow(logic [CFG_IDX_W-1:0] idx, t_quat data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row vrow(t_vec x, t_vec y, t_vec z);
        t_row r;
        r = '0;
        r.kind  = ROW_VEC;
        r.vec.x = x;
        r.vec.y = y;
        r.vec.z = z;
        return r;
    endfunction

    function automatic t_row erow(t_vec x, t_vec y, t_vec z,
                                  t_vec ex, t_vec ey, t_vec ez);
        t_row r;
        r = vrow(x, y, z);
        r.typed  = 1'b1;
        r.want.x = ex;
        r.want.y = ey;
        r.want.z = ez;
        return r;
    endfunction

    function automatic t_vec rand_comp();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return VEC_MAX;
                    1:       return VEC_MIN;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            1, 2, 3, 4: return t_vec'($urandom);
            default:    return t_vec'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic t_quat rand_quat(int mode);
        case (mode)
            0: return t_quat'($urandom);
            1: return t_quat'(int'($urandom_range(0, 32768)) - 16384);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return Q_ONE;
                    1:       return -Q_ONE;
                    2:       return Q_MOST_POS;
                    3:       return Q_MOST_NEG;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_quat data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_QUAT_X: quat_x = data;
            REG_QUAT_Y: quat_y = data;
            REG_QUAT_Z: quat_z = data;
            REG_QUAT_W: quat_w = data;
            default: ;
        endcase
    endtask

    task automatic offer_vec(t_vec vx, t_vec vy, t_vec vz, logic typed, t_vec3 want);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_vec_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_vec_x       = vx;
        i_vec_y       = vy;
        i_vec_z       = vz;
        use_table_rot = typed;
        table_rot     = want;
        i_vec_valid   = 1'b1;
        do @(posedge i_clk); while (!o_vec_ready);
    endtask

    // let the pipeline run empty before touching the quaternion
    task automatic drain_pipe();
        @(negedge i_clk);
        i_vec_valid = 1'b0;
        while (pending_rot.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic check_field(string name, t_vec want, t_vec got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d (%h), got %0d (%h)",
                     $time, name, want, want, got, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vec3 want;
        if (i_rst_n) begin
            if (o_rot_valid && i_rot_ready) begin
                rot_seen++;
                if (pending_rot.size() == 0) begin
                    $display("%0t: result with none expected, got %h %h %h",
                             $time, o_rot_x, o_rot_y, o_rot_z);
                    mismatches++;
                end else begin
                    want = pending_rot.pop_front();
                    check_field("rot_x", want.x, o_rot_x);
                    check_field("rot_y", want.y, o_rot_y);
                    check_field("rot_z", want.z, o_rot_z);
                end
            end
            if (i_vec_valid && o_vec_ready)
                pending_rot.push_back(use_table_rot ? table_rot
                                                    : rotate(i_vec_x, i_vec_y, i_vec_z));
        end
    end

    // receiver: random stalls, stall-free stretches, one long hold-off
    initial begin
        int stall;
        bit held;
        held        = 1'b0;
        i_rot_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && rot_seen >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else if ((rot_seen / 128) % 3 == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
            end
            if (stall > 0) begin
                i_rot_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_rot_ready = 1'b1;
            do @(posedge i_clk); while (!o_rot_valid);
        end
    end

    initial begin
        t_row row;
        bit   idle;
        int   mode;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_vec_valid   = 1'b0;
        i_vec_x       = '0;
        i_vec_y       = '0;
        i_vec_z       = '0;
        use_table_rot = 1'b0;
        table_rot     = '0;
        burst_mode    = 1'b0;
        mismatches    = 0;
        rot_seen      = 0;
        quat_x        = '0;
        quat_y        = '0;
        quat_z        = '0;
        quat_w        = Q_ONE;

        // identity after reset
        dir_rows.push_back(erow(0, 0, 0, 0, 0, 0));
        dir_rows.push_back(erow(VEC_MAX, VEC_MIN, -1, VEC_MAX, VEC_MIN, -1));
        dir_rows.push_back(erow(VEC_MIN, VEC_MAX, 1, VEC_MIN, VEC_MAX, 1));
        // w = 1 lsb: result is v / 2^28, ties round up
        dir_rows.push_back(crow(REG_QUAT_W, 16'sd1));
        dir_rows.push_back(erow(V_HALF_LSB, -V_HALF_LSB, V_HALF_LSB - 1, 1, 0, 0));
        dir_rows.push_back(erow(-V_HALF_LSB - 1, VEC_MAX, VEC_MIN, -1, 8, -8));
        // most negative w: scale by four, saturating
        dir_rows.push_back(crow(REG_QUAT_W, Q_MOST_NEG));
        dir_rows.push_back(erow(VEC_MAX, VEC_MIN, 32'sd536870912, VEC_MAX, VEC_MIN, VEC_MAX));
        dir_rows.push_back(erow(3, -5, 0, 12, -20, 0));
        // half turn about x
        dir_rows.push_back(crow(REG_QUAT_W, '0));
        dir_rows.push_back(crow(REG_QUAT_X, Q_ONE));
        dir_rows.push_back(erow(100, 200, VEC_MIN, 100, -200, VEC_MAX));
        dir_rows.push_back(erow(VEC_MIN, 1, -1, VEC_MIN, -1, 1));
        // half turn about z
        dir_rows.push_back(crow(REG_QUAT_X, '0));
        dir_rows.push_back(crow(REG_QUAT_Z, Q_ONE));
        dir_rows.push_back(erow(7, -9, 11, -7, 9, 11));
        // writes to unused indexes change nothing
        dir_rows.push_back(crow(IDX_SPARE_HI, Q_MOST_POS));
        dir_rows.push_back(crow(IDX_SPARE_LO, Q_MOST_NEG));
        dir_rows.push_back(erow(7, -9, 11, -7, 9, 11));
        // quarter turn about z
        dir_rows.push_back(crow(REG_QUAT_W, Q_COS45));
        dir_rows.push_back(crow(REG_QUAT_Z, Q_COS45));
        dir_rows.push_back(vrow(65536, 0, 0));
        dir_rows.push_back(vrow(0, 65536, 65536));
        // non-unit quaternion
        dir_rows.push_back(crow(REG_QUAT_X, Q_ONE));
        dir_rows.push_back(crow(REG_QUAT_Y, Q_ONE));
        dir_rows.push_back(crow(REG_QUAT_Z, Q_ONE));
        dir_rows.push_back(crow(REG_QUAT_W, Q_ONE));
        dir_rows.push_back(vrow(VEC_MAX, VEC_MAX, VEC_MAX));
        dir_rows.push_back(vrow(32'sd1048576, -32'sd1048576, 12345));
        // components at the top of the Q1.14 range
        dir_rows.push_back(crow(REG_QUAT_X, Q_MOST_POS));
        dir_rows.push_back(crow(REG_QUAT_Y, Q_MOST_POS));
        dir_rows.push_back(crow(REG_QUAT_Z, Q_MOST_POS));
        dir_rows.push_back(crow(REG_QUAT_W, Q_MOST_POS));
        dir_rows.push_back(vrow(VEC_MIN, 0, VEC_MAX));
        dir_rows.push_back(vrow(-32'sd65536, 32'sd65536, 1));
        dir_rows.push_back(crow(REG_QUAT_X, -Q_ONE));
        dir_rows.push_back(crow(REG_QUAT_Y, -Q_ONE));
        dir_rows.push_back(crow(REG_QUAT_Z, -Q_ONE));
        dir_rows.push_back(crow(REG_QUAT_W, -Q_ONE));
        dir_rows.push_back(vrow(VEC_MAX, VEC_MIN, VEC_MAX));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle = 1'b1;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                if (!idle) begin
                    drain_pipe();
                    idle = 1'b1;
                end
                write_reg(row.idx, row.data);
            end else begin
                if (idle) begin
                    repeat (2) @(negedge i_clk);
                    idle = 1'b0;
                end
                offer_vec(row.vec.x, row.vec.y, row.vec.z, row.typed, row.want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_pipe();
            mode = (p == 0 || p == N_PHASES - 1) ? 2 : (p % 3 == 0) ? 0 : 1;
            write_reg(REG_QUAT_X, rand_quat(mode));
            write_reg(REG_QUAT_Y, rand_quat(mode));
            write_reg(REG_QUAT_Z, rand_quat(mode));
            write_reg(REG_QUAT_W, rand_quat(mode));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(4, 255)), t_quat'($urandom));
            repeat (2) @(negedge i_clk);
            burst_mode = (p % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
        end

        @(negedge i_clk);
        i_vec_valid = 1'b0;
        while (pending_rot.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hdl/qrv_pkg.sv
hdl/qrv_coef.sv
hdl/qrv_dot.sv
hdl/quaternion_rotate_vector.sv
hdl/qrv_checker.sv
sim/testbench.sv
